>>> src/lfhp_pkg.sv
// ----------------------------------------------------------------------------
// lfhp_pkg
// Shared types and constants of the LoRaWAN frame header parser.
// ----------------------------------------------------------------------------
package lfhp_pkg;

  // Byte count width: holds the saturated count of up to 256 bytes
  localparam int COUNT_W    = 9;
  // Number of leading frame bytes kept for header decode
  localparam int HEAD_DEPTH = 19;

  // Byte positions inside the frame header
  localparam int FCTRL_POS  = 5;
  localparam int FOPTS_BASE = 8;

  // Header masks
  localparam logic [7:0] MHDR_VER_MASK  = 8'b0001_1111;
  localparam logic [7:0] FCTRL_OPT_MASK = 8'h0F;

  // Size limits by frame type
  localparam logic [COUNT_W-1:0] JOIN_REQ_MIN = COUNT_W'(1 + 3 + 3 + 4 + 1 + 1 + 4);
  localparam logic [COUNT_W-1:0] JOIN_REQ_MAX = COUNT_W'(1 + 3 + 3 + 4 + 1 + 1 + 4 + 16);
  localparam logic [COUNT_W-1:0] JOIN_ACC_LEN = COUNT_W'(1 + 8 + 8 + 2 + 4);
  localparam logic [COUNT_W-1:0] DATA_MIN     = COUNT_W'(1 + 4 + 1 + 2 + 4);

  // Port value reported when a frame has no port byte
  localparam logic [7:0] NO_PORT = 8'hFF;

  // MType codes
  typedef enum logic [2:0] {
    MT_JOIN_REQ   = 3'd0,
    MT_JOIN_ACC   = 3'd1,
    MT_UNC_UP     = 3'd2,
    MT_UNC_DN     = 3'd3,
    MT_CNF_UP     = 3'd4,
    MT_CNF_DN     = 3'd5,
    MT_REJOIN     = 3'd6,
    MT_PROPRIETARY = 3'd7
  } mtype_t;

  // Captured head bytes, entry 0 in the low byte
  typedef logic [HEAD_DEPTH-1:0][7:0] head_t;

  // One decoded frame
  typedef struct packed {
    logic        frame_valid;
    logic [2:0]  msg_type;
    logic [31:0] dev_addr;
    logic [15:0] frame_count;
    logic [2:0]  frame_flags;
    logic [7:0]  port;
    logic [7:0]  payload_len;
    logic [31:0] mic;
    logic [63:0] join_eui;
    logic [63:0] dev_eui;
    logic [15:0] dev_nonce;
  } result_t;

endpackage

>>> src/lorawan_frame_header_parser_core.sv
// ----------------------------------------------------------------------------
// lorawan_frame_header_parser_core
// Byte-stream LoRaWAN frame header parser: captures header, port and MIC
// bytes as they arrive and emits one decoded word per frame.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, no gap between frames, unless the output stalls.
// Output: the last byte is captured at its accepting edge, and the decoded
//   result word is loaded into the output register once the output slot is
//   free.
// Reset: synchronous active-low rst_n clears byte count, port, tail and all
//   flags; captured header bytes hold undefined values until written.
// ----------------------------------------------------------------------------
module lorawan_frame_header_parser_core import lfhp_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 255
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tlast,   // last_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [247:0] out_tdata,  // [31:0] dev_addr, [47:32] frame_count,
                                   // [50:48] frame_flags, [58:51] port,
                                   // [66:59] payload_len, [98:67] mic,
                                   // [162:99] join_eui, [226:163] dev_eui,
                                   // [242:227] dev_nonce, [247:243] zero
  output logic [3:0]   out_tuser   // [0] frame_valid, [3:1] msg_type
);

  localparam logic [COUNT_W-1:0] SAT_COUNT = COUNT_W'(MAX_FRAME_BYTES + 1);

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               done_r, done_nxt;
  logic               pend_r, pend_nxt;
  head_t              head_r;
  logic [7:0]         port_r;
  logic [31:0]        tail_r;
  logic               out_valid_r, out_valid_nxt;
  result_t            out_r;
  result_t            dec_result;

  logic               in_acc;
  logic               slot_free;
  logic               move;
  logic [COUNT_W-1:0] pos;
  logic [COUNT_W-1:0] port_pos;
  logic [31:0]        tail_base;

  // Handshake: stall input only while a finished frame cannot move out
  assign slot_free = !out_valid_r || out_tready;
  assign move      = pend_r && slot_free;
  assign in_tready = !pend_r || slot_free;
  assign in_acc    = in_tvalid && in_tready;

  // Position of the incoming byte: restart after a finished frame
  assign pos       = done_r ? '0 : count_r;
  assign port_pos  = COUNT_W'(FOPTS_BASE) + COUNT_W'(head_r[FCTRL_POS] & FCTRL_OPT_MASK);
  assign tail_base = (pos == '0) ? 32'h0 : tail_r;

  // Next byte count and frame flags
  always_comb begin
    count_nxt = count_r;
    done_nxt  = done_r;
    if (in_acc) begin
      count_nxt = (pos < SAT_COUNT) ? pos + COUNT_W'(1) : pos;
      done_nxt  = in_tlast;
    end
    pend_nxt      = (in_acc && in_tlast) || (pend_r && !move);
    out_valid_nxt = move || (out_valid_r && !out_tready);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      done_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      port_r      <= 8'h00;
      tail_r      <= 32'h0;
    end else begin
      count_r     <= count_nxt;
      done_r      <= done_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        tail_r <= {in_tdata, tail_base[31:8]};
        if (pos > COUNT_W'(FCTRL_POS) && pos == port_pos) begin
          port_r <= in_tdata;
        end
      end
    end
  end

  // Capture the leading header bytes
  always_ff @(posedge clk) begin
    for (int i = 0; i < HEAD_DEPTH; i++) begin
      if (in_acc && pos == COUNT_W'(i)) begin
        head_r[i] <= in_tdata;
      end
    end
  end

  lfhp_decode #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_decode (
    .head       (head_r),
    .byte_total (count_r),
    .port_byte  (port_r),
    .tail_word  (tail_r),
    .result     (dec_result)
  );

  // Load the output register when a finished frame moves out
  always_ff @(posedge clk) begin
    if (move) begin
      out_r <= dec_result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {out_r.msg_type, out_r.frame_valid};
  assign out_tdata  = {5'b0, out_r.dev_nonce, out_r.dev_eui, out_r.join_eui, out_r.mic,
                       out_r.payload_len, out_r.port, out_r.frame_flags,
                       out_r.frame_count, out_r.dev_addr};

endmodule

>>> src/lfhp_decode.sv
// ----------------------------------------------------------------------------
// lfhp_decode
// Decodes the captured bytes of one finished frame into header fields and
// a validity verdict by type and size.
// ----------------------------------------------------------------------------
module lfhp_decode import lfhp_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 255
) (
  input  head_t                head,
  input  logic [COUNT_W-1:0]   byte_total,
  input  logic [7:0]           port_byte,
  input  logic [31:0]          tail_word,
  output result_t              result
);

  localparam logic [COUNT_W-1:0] MAX_SIZE = COUNT_W'(MAX_FRAME_BYTES);

  head_t               hb;
  logic [7:0]          b0;
  logic [7:0]          fctrl;
  logic [COUNT_W-1:0]  optlen;
  logic [COUNT_W-1:0]  no_port_lim;
  logic [COUNT_W-1:0]  plen_full;
  logic                fits;
  mtype_t              mtype;

  // Mask bytes beyond the frame size to zero
  always_comb begin
    for (int i = 0; i < HEAD_DEPTH; i++) begin
      hb[i] = (COUNT_W'(i) < byte_total) ? head[i] : 8'h00;
    end
  end

  assign b0          = hb[0];
  assign fctrl       = hb[FCTRL_POS];
  assign mtype       = mtype_t'(b0[7:5]);
  assign optlen      = COUNT_W'(fctrl & FCTRL_OPT_MASK);
  assign no_port_lim = DATA_MIN + optlen;
  assign plen_full   = byte_total - no_port_lim - COUNT_W'(1);

  // Check size against the frame type
  always_comb begin
    unique case (mtype)
      MT_PROPRIETARY:         fits = 1'b0;
      MT_JOIN_REQ, MT_REJOIN: fits = (byte_total >= JOIN_REQ_MIN) &&
                                     (byte_total <= JOIN_REQ_MAX);
      MT_JOIN_ACC:            fits = (byte_total == JOIN_ACC_LEN);
      default:                fits = (byte_total >= DATA_MIN);
    endcase
  end

  // Assemble the result fields
  always_comb begin
    result.frame_valid = fits && (byte_total <= MAX_SIZE) &&
                         ((b0 & MHDR_VER_MASK) == 8'h00);
    result.msg_type    = b0[7:5];
    result.dev_addr    = {hb[4], hb[3], hb[2], hb[1]};
    result.frame_count = {hb[7], hb[6]};
    result.frame_flags = {fctrl[7], fctrl[5], fctrl[4]};
    if (byte_total <= no_port_lim) begin
      result.port        = NO_PORT;
      result.payload_len = 8'h00;
    end else begin
      result.port        = port_byte;
      result.payload_len = plen_full[7:0];
    end
    result.mic       = tail_word;
    result.join_eui  = {hb[8], hb[7], hb[6], hb[5], hb[4], hb[3], hb[2], hb[1]};
    result.dev_eui   = {hb[16], hb[15], hb[14], hb[13], hb[12], hb[11], hb[10], hb[9]};
    result.dev_nonce = {hb[18], hb[17]};
  end

endmodule

>>> verif/lorawan_frame_header_parser_core_tb.sv
// ----------------------------------------------------------------------------
// lorawan_frame_header_parser_core_tb
// Streams LoRaWAN frames into the header parser one byte word at a time and
// checks every decoded result word against a cycle-free model of the parser.
// The run starts with directed frames at the size limits of each message type,
// then sends random frames. Both sides of the stream insert random gaps.
// ----------------------------------------------------------------------------
module lorawan_frame_header_parser_core_tb;
  import lfhp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_FRAME_BYTES = 255;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 10;
  localparam int RANDOM_BYTES    = 50;
  localparam int RANDOM_FRAMES   = 3;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } stream_word_t;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata   = 8'h00;
  logic         in_tlast   = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [247:0] out_tdata;
  logic [3:0]   out_tuser;

  // Byte words waiting to be sent and decoded frames waiting to come back
  stream_word_t tx_words[$];
  result_t      decoded_frames[$];

  // Model state of the parser
  logic [8:0]   rx_count = '0;
  logic [7:0]   rx_head[HEAD_DEPTH];
  logic [7:0]   rx_port  = '0;
  logic [31:0]  rx_tail  = '0;

  // Handshake flags seen at the last rising edge
  logic         in_taken  = 1'b0;
  logic         out_taken = 1'b0;

  int send_wait, send_burst, sink_wait, sink_burst;
  int frames_queued, bytes_queued, bytes_sent, results_seen;
  int valid_frames, oversize_frames, mismatches, idle_cycles;
  logic [7:0] types_seen = '0;

  lorawan_frame_header_parser_core #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  // Header byte as the parser sees it: zero beyond the frame or the capture
  function automatic logic [7:0] head_byte(int idx, int size);
    if (idx >= HEAD_DEPTH || idx >= size) return 8'h00;
    return rx_head[idx];
  endfunction

  function automatic logic [63:0] head_le(int first, int n, int size);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < n; i++) v |= 64'(head_byte(first + i, size)) << (8 * i);
    return v;
  endfunction

  function automatic logic size_allowed(logic [7:0] mhdr, int size);
    if (size > MAX_FRAME_BYTES) return 1'b0;
    if ((mhdr & MHDR_VER_MASK) != 8'h00) return 1'b0;
    case (mtype_t'(mhdr[7:5]))
      MT_PROPRIETARY: return 1'b0;
      MT_JOIN_REQ, MT_REJOIN: return size >= JOIN_REQ_MIN && size <= JOIN_REQ_MAX;
      MT_JOIN_ACC: return size == JOIN_ACC_LEN;
      default: return size >= DATA_MIN;
    endcase
  endfunction

  // Advance the model by one accepted byte; queue the decoded frame on the last
  task automatic parse_byte(logic [7:0] b, logic last);
    int pos, size, optlen;
    logic [7:0] mhdr, fctrl;
    result_t r;
    pos = rx_count;
    if (pos == 0) rx_tail = '0;
    if (pos < HEAD_DEPTH) rx_head[pos] = b;
    if (pos > FCTRL_POS && pos == FOPTS_BASE + int'(rx_head[FCTRL_POS] & FCTRL_OPT_MASK))
      rx_port = b;
    rx_tail = {b, rx_tail[31:8]};
    if (int'(rx_count) <= MAX_FRAME_BYTES) rx_count++;
    if (!last) return;

    size   = rx_count;
    mhdr   = head_byte(0, size);
    fctrl  = head_byte(FCTRL_POS, size);
    optlen = fctrl & FCTRL_OPT_MASK;
    r.frame_valid = size_allowed(mhdr, size);
    r.msg_type    = mhdr[7:5];
    r.dev_addr    = head_le(1, 4, size);
    r.frame_count = head_le(6, 2, size);
    r.frame_flags = {fctrl[7], fctrl[5], fctrl[4]};
    if (size <= 12 + optlen) begin
      r.port        = NO_PORT;
      r.payload_len = 8'h00;
    end else begin
      r.port        = rx_port;
      r.payload_len = 8'(size - 13 - optlen);
    end
    r.mic       = rx_tail;
    r.join_eui  = head_le(1, 8, size);
    r.dev_eui   = head_le(9, 8, size);
    r.dev_nonce = head_le(17, 2, size);
    decoded_frames.push_back(r);
    if (size > MAX_FRAME_BYTES) oversize_frames++;
    rx_count = '0;
    rx_tail  = '0;
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Compare one result word with the oldest decoded frame
  task automatic check_result();
    result_t want;
    results_seen++;
    if (decoded_frames.size() == 0) begin
      report_mismatch("result word with no frame pending", 64'(out_tuser), '0);
      return;
    end
    want = decoded_frames.pop_front();
    check_field("frame_valid", out_tuser[0], want.frame_valid);
    check_field("msg_type", out_tuser[3:1], want.msg_type);
    check_field("dev_addr", out_tdata[31:0], want.dev_addr);
    check_field("frame_count", out_tdata[47:32], want.frame_count);
    check_field("frame_flags", out_tdata[50:48], want.frame_flags);
    check_field("port", out_tdata[58:51], want.port);
    check_field("payload_len", out_tdata[66:59], want.payload_len);
    check_field("mic", out_tdata[98:67], want.mic);
    check_field("join_eui", out_tdata[162:99], want.join_eui);
    check_field("dev_eui", out_tdata[226:163], want.dev_eui);
    check_field("dev_nonce", out_tdata[242:227], want.dev_nonce);
    check_field("tdata padding", out_tdata[247:243], '0);
    if (want.frame_valid) valid_frames++;
    types_seen[want.msg_type] = 1'b1;
  endtask

  // Gap after a word: mostly random, with occasional gap-free runs
  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 5);
  endfunction

  // Sample both handshakes, update the model, check results, run the watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      in_taken  <= in_tvalid && in_tready;
      out_taken <= out_tvalid && out_tready;
      if (in_tvalid && in_tready) begin
        parse_byte(in_tdata, in_tlast);
        bytes_sent++;
      end
      if (out_tvalid && out_tready) check_result();
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Drive byte words: hold until accepted, then wait out the drawn gap
  always @(negedge clk) begin : drive_bytes
    stream_word_t w;
    if (rst_n) begin
      if (in_tvalid && !in_taken) begin
        // hold the current word
      end else if (send_wait > 0) begin
        send_wait--;
        in_tvalid <= 1'b0;
      end else if (tx_words.size() > 0) begin
        w = tx_words.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= w.data;
        in_tlast  <= w.last;
        send_wait = draw_wait(send_burst);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Drive out_tready: stall for a drawn gap after each result
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) sink_wait = draw_wait(sink_burst);
      if (sink_wait > 0) begin
        sink_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Queue one frame with random content, a given MHDR and FCtrl byte
  task automatic queue_frame(logic [7:0] mhdr, logic [7:0] fctrl, int size);
    stream_word_t w;
    for (int i = 0; i < size; i++) begin
      w.data = (i == 0) ? mhdr : (i == FCTRL_POS) ? fctrl : 8'($urandom);
      w.last = (i == size - 1);
      tx_words.push_back(w);
    end
    frames_queued++;
    bytes_queued += size;
  endtask

  // Data frame sized from its options length plus extra bytes past the header
  task automatic queue_data_frame(mtype_t mt, logic [7:0] fctrl, int extra);
    queue_frame({mt, 5'b0}, fctrl, 12 + int'(fctrl & FCTRL_OPT_MASK) + extra);
  endtask

  task automatic wait_all_results();
    while (results_seen < frames_queued || tx_words.size() > 0) @(negedge clk);
  endtask

  initial begin
    int sel, start_bytes, start_frames;
    bit paused;
    logic [7:0] fctrl;
    foreach (rx_head[i]) rx_head[i] = 8'h00;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: first frame fills every captured header byte
    queue_frame({MT_JOIN_ACC, 5'b0}, 8'($urandom), 23);
    queue_frame({MT_JOIN_REQ, 5'b0}, 8'($urandom), 23);
    queue_frame({MT_JOIN_REQ, 5'b0}, 8'($urandom), 17);
    queue_frame({MT_REJOIN, 5'b0}, 8'($urandom), 33);
    queue_frame({MT_JOIN_REQ, 5'b0}, 8'($urandom), 16);
    queue_frame({MT_REJOIN, 5'b0}, 8'($urandom), 34);
    queue_frame({MT_JOIN_ACC, 5'b0}, 8'($urandom), 22);
    queue_frame({MT_JOIN_ACC, 5'b0}, 8'($urandom), 24);
    // Data frames around the minimum size and the port boundary
    queue_data_frame(MT_UNC_UP, 8'h00, 0);
    queue_data_frame(MT_UNC_DN, 8'h00, -1);
    queue_data_frame(MT_CNF_UP, 8'hB0, 1);
    queue_data_frame(MT_CNF_DN, 8'hFF, 0);
    queue_data_frame(MT_UNC_UP, 8'h0F, 1);
    queue_data_frame(MT_CNF_UP, 8'h40, 20);
    // Proprietary type and nonzero version bits
    queue_frame({MT_PROPRIETARY, 5'b0}, 8'h00, 12);
    queue_frame(8'h5F, 8'h00, 12);
    // Short frames with a partial MIC
    for (int n = 1; n <= 4; n++) queue_frame({MT_UNC_UP, 5'b0}, 8'h00, n);
    // Oversize frame: the count saturates before the last byte
    queue_data_frame(MT_UNC_DN, 8'h25, MAX_FRAME_BYTES - 15);

    // Queue nothing more until every result is back
    wait_all_results();

    // Random frames, mostly well formed data frames
    start_bytes  = bytes_queued;
    start_frames = frames_queued;
    paused       = 1'b0;
    while (bytes_queued - start_bytes < RANDOM_BYTES ||
           frames_queued - start_frames < RANDOM_FRAMES) begin
      sel = $urandom_range(0, 19);
      if (sel <= 11) begin
        fctrl = 8'($urandom);
        if ($urandom_range(0, 3) != 0) fctrl[3:0] = 4'($urandom_range(0, 2));
        queue_data_frame(mtype_t'($urandom_range(MT_UNC_UP, MT_CNF_DN)), fctrl,
                         $urandom_range(0, 24));
      end else if (sel <= 13) begin
        queue_frame({$urandom_range(0, 1) ? MT_REJOIN : MT_JOIN_REQ, 5'b0}, 8'($urandom),
                    $urandom_range(15, 35));
      end else if (sel == 14) begin
        queue_frame({MT_JOIN_ACC, 5'b0}, 8'($urandom), $urandom_range(21, 25));
      end else if (sel == 15) begin
        queue_frame(8'($urandom), 8'($urandom), $urandom_range(1, 40));
      end else if (sel <= 18) begin
        queue_frame({3'($urandom), 5'b0}, 8'($urandom), $urandom_range(1, 14));
      end else begin
        queue_data_frame(MT_CNF_UP, 8'($urandom) | 8'h0F, $urandom_range(0, 8));
      end
      // Drain once more halfway through
      if (!paused && bytes_queued - start_bytes >= RANDOM_BYTES / 2) begin
        paused = 1'b1;
        wait_all_results();
      end
    end

    // Let everything drain, then allow for the output pipeline
    wait_all_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (decoded_frames.size() != 0)
      report_mismatch("frames never delivered", decoded_frames.size(), '0);

    $display("Checked %0d frames from %0d bytes: %0d valid, %0d oversize",
             results_seen, bytes_sent, valid_frames, oversize_frames);
    $display("Message types seen (bit per MType): %b, mismatches: %0d",
             types_seen, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
